// ----- src/i2cm_pkg.sv -----
// shared types and constants for the i2c master byte engine
package i2cm_pkg;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       sda_in;
    logic       scl_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       ready_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic [2:0] status;
  } out_item_t;

  typedef struct packed {
    logic [15:0] phase_ticks;
    logic        stretch_enable;
    logic [15:0] stretch_limit;
    logic [7:0]  recovery_pulses;
  } cfg_t;

  localparam logic [2:0] OP_NONE  = 3'd0;
  localparam logic [2:0] OP_START = 3'd1;
  localparam logic [2:0] OP_WADDR = 3'd2;
  localparam logic [2:0] OP_WDATA = 3'd3;
  localparam logic [2:0] OP_RACK  = 3'd4;
  localparam logic [2:0] OP_RNACK = 3'd5;
  localparam logic [2:0] OP_STOP  = 3'd6;
  localparam logic [2:0] OP_RSVD  = 3'd7;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_DNACK    = 3'd1;
  localparam logic [2:0] ST_ANACK    = 3'd2;
  localparam logic [2:0] ST_TIMEOUT  = 3'd3;
  localparam logic [2:0] ST_RECFAIL  = 3'd4;

  localparam logic [1:0] REG_PHASE   = 2'd0;
  localparam logic [1:0] REG_STR_EN  = 2'd1;
  localparam logic [1:0] REG_STR_LIM = 2'd2;
  localparam logic [1:0] REG_REC     = 2'd3;

  localparam int QDEPTH = 2;

endpackage

// ----- src/i2cm_queue.sv -----
// two-entry beat queue between front and back with skid behaviour
module i2cm_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_valid,
  output logic               wr_stall,
  input  i2cm_pkg::in_item_t wr_data,
  output logic               rd_valid,
  input  logic               rd_take,
  output i2cm_pkg::in_item_t rd_data
);
  import i2cm_pkg::*;

  in_item_t   mem [QDEPTH];
  logic       wptr, rptr;
  logic [1:0] count;
  logic       push, pop;

  assign rd_valid = (count != 2'd0);
  assign wr_stall = (count == 2'd2);
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_valid && rd_take;
  assign rd_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_data;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- src/i2cm_front.sv -----
// input side: takes beats and masks operation codes that mean nothing
module i2cm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  i2cm_pkg::in_item_t in_data,
  output logic               q_valid,
  input  logic               q_stall,
  output i2cm_pkg::in_item_t q_data
);
  import i2cm_pkg::*;

  in_item_t cls;

  always_comb begin
    cls = in_data;
    if (in_data.operation == OP_RSVD) cls.operation = OP_NONE;
  end

  // single register stage, refilled whenever the queue takes it
  logic     held;
  in_item_t hold_data;

  assign in_stall = held && q_stall;
  assign q_valid  = held;
  assign q_data   = hold_data;

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) hold_data <= cls;
    if (rst) begin
      held <= 1'b0;
    end else if (!in_stall) begin
      held <= in_valid;
    end
  end
endmodule

// ----- src/i2cm_back.sv -----
// bit timing sequencer: one beat per tick while the output is not stalled, one result beat per input beat
module i2cm_back (
  input  logic                clk,
  input  logic                rst,
  input  i2cm_pkg::cfg_t      cfg,
  input  logic                q_valid,
  output logic                q_take,
  input  i2cm_pkg::in_item_t  q_data,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cm_pkg::out_item_t out_data
);
  import i2cm_pkg::*;

  localparam logic [4:0] PH_IDLE = 5'd0, PH_CHK1 = 5'd1, PH_CHK2 = 5'd2,
    PH_REC_TEST = 5'd3, PH_REC_LOW = 5'd4, PH_REC_HIGH = 5'd5, PH_START1 = 5'd6,
    PH_START2 = 5'd7, PH_WLOW = 5'd8, PH_WSTRETCH = 5'd9, PH_WHIGH = 5'd10,
    PH_WACKLOW = 5'd11, PH_WACKHIGH = 5'd12, PH_RLOW = 5'd13, PH_RSTRETCH = 5'd14,
    PH_RHIGH = 5'd15, PH_RACKLOW = 5'd16, PH_RACKHIGH = 5'd17, PH_STOP1 = 5'd18,
    PH_STOP2 = 5'd19, PH_STOP3 = 5'd20;

  logic [4:0]  phase_state, phase_state_next;
  logic [15:0] phase_counter, phase_counter_next;
  logic [3:0]  bit_index, bit_index_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [15:0] stretch_counter, stretch_counter_next;
  logic [7:0]  recovery_counter, recovery_counter_next;
  logic [2:0]  last_status, last_status_next;
  logic        auto_stop, auto_stop_next;
  logic        scl_drv, scl_drv_next, sda_drv, sda_drv_next;
  logic [7:0]  rx_reg, rx_reg_next;
  logic [2:0]  cmd, cmd_next;
  logic        done_next;

  logic        ov;
  out_item_t   obuf;
  logic        step;

  logic [15:0] ticks;
  logic [3:0]  bi_inc;
  logic [2:0]  op;
  logic        sda, scl;

  // result register advances when empty or being taken
  assign step     = q_valid && (!ov || !out_stall);
  assign q_take   = step;
  assign out_valid = ov;
  assign out_data  = obuf;

  assign ticks  = (cfg.phase_ticks == 16'd0) ? 16'd1 : cfg.phase_ticks;
  assign op     = q_data.operation;
  assign sda    = q_data.sda_in;
  assign scl    = q_data.scl_in;
  assign bi_inc = bit_index + 4'd1;

  always_comb begin
    phase_state_next      = phase_state;
    phase_counter_next    = phase_counter;
    bit_index_next        = bit_index;
    shift_byte_next       = shift_byte;
    stretch_counter_next  = stretch_counter;
    recovery_counter_next = recovery_counter;
    last_status_next      = last_status;
    auto_stop_next        = auto_stop;
    scl_drv_next          = scl_drv;
    sda_drv_next          = sda_drv;
    rx_reg_next           = rx_reg;
    cmd_next              = cmd;
    done_next             = 1'b0;

    if (phase_state == PH_IDLE) begin
      unique case (op)
        OP_START: begin
          cmd_next = op;
          phase_state_next = PH_CHK1; phase_counter_next = ticks;
        end
        OP_WADDR, OP_WDATA: begin
          cmd_next = op; shift_byte_next = q_data.data_byte; bit_index_next = 4'd0;
          scl_drv_next = 1'b1; sda_drv_next = ~q_data.data_byte[7];
          phase_state_next = PH_WLOW; phase_counter_next = ticks;
        end
        OP_RACK, OP_RNACK: begin
          cmd_next = op; shift_byte_next = 8'd0; bit_index_next = 4'd0;
          scl_drv_next = 1'b1; sda_drv_next = 1'b0;
          phase_state_next = PH_RLOW; phase_counter_next = ticks;
        end
        OP_STOP: begin
          cmd_next = op; auto_stop_next = 1'b0; sda_drv_next = 1'b1;
          phase_state_next = PH_STOP1; phase_counter_next = ticks;
        end
        default: ;
      endcase
    end else if (phase_state == PH_REC_TEST) begin
      if (recovery_counter == 8'd0) begin
        phase_state_next = PH_IDLE; phase_counter_next = 16'd0;
        last_status_next = ST_RECFAIL; done_next = 1'b1;
      end else if (sda) begin
        sda_drv_next = 1'b1; phase_state_next = PH_START1; phase_counter_next = ticks;
      end else begin
        recovery_counter_next = recovery_counter - 8'd1;
        scl_drv_next = 1'b1; phase_state_next = PH_REC_LOW; phase_counter_next = ticks;
      end
    end else if (phase_state == PH_WSTRETCH || phase_state == PH_RSTRETCH) begin
      if (scl) begin
        phase_state_next = (phase_state == PH_WSTRETCH) ? PH_WHIGH : PH_RHIGH;
        phase_counter_next = ticks;
      end else begin
        stretch_counter_next = stretch_counter - 16'd1;
        if (stretch_counter == 16'd1) begin
          last_status_next = ST_TIMEOUT; auto_stop_next = 1'b1; sda_drv_next = 1'b1;
          phase_state_next = PH_STOP1; phase_counter_next = ticks;
        end
      end
    end else begin
      phase_counter_next = phase_counter - 16'd1;
      if (phase_counter == 16'd1) begin
        unique case (phase_state)
          PH_CHK1: begin
            scl_drv_next = 1'b0; sda_drv_next = 1'b0;
            phase_state_next = PH_CHK2; phase_counter_next = ticks;
          end
          PH_CHK2: begin
            if (sda) begin
              sda_drv_next = 1'b1; phase_state_next = PH_START1;
              phase_counter_next = ticks;
            end else begin
              recovery_counter_next = cfg.recovery_pulses;
              phase_state_next = PH_REC_TEST;
            end
          end
          PH_REC_LOW: begin
            scl_drv_next = 1'b0; phase_state_next = PH_REC_HIGH;
            phase_counter_next = ticks;
          end
          PH_REC_HIGH: phase_state_next = PH_REC_TEST;
          PH_START1: begin
            scl_drv_next = 1'b1; phase_state_next = PH_START2; phase_counter_next = ticks;
          end
          PH_START2: begin
            phase_state_next = PH_IDLE; last_status_next = ST_OK; done_next = 1'b1;
          end
          PH_WLOW, PH_RLOW: begin
            scl_drv_next = 1'b0;
            if (bit_index == 4'd0 && cfg.stretch_enable) begin
              phase_state_next = (phase_state == PH_WLOW) ? PH_WSTRETCH : PH_RSTRETCH;
              stretch_counter_next = (cfg.stretch_limit == 16'd0) ? 16'd1
                                                                   : cfg.stretch_limit;
            end else begin
              phase_state_next = (phase_state == PH_WLOW) ? PH_WHIGH : PH_RHIGH;
              phase_counter_next = ticks;
            end
          end
          PH_WHIGH: begin
            bit_index_next = bi_inc;
            scl_drv_next = 1'b1;
            phase_counter_next = ticks;
            if (bi_inc < 4'd8) begin
              sda_drv_next = ~shift_byte[3'd7 - bi_inc[2:0]];
              phase_state_next = PH_WLOW;
            end else begin
              sda_drv_next = 1'b0; phase_state_next = PH_WACKLOW;
            end
          end
          PH_WACKLOW: begin
            scl_drv_next = 1'b0; phase_state_next = PH_WACKHIGH; phase_counter_next = ticks;
          end
          PH_WACKHIGH: begin
            scl_drv_next = 1'b1;
            if (!sda) begin
              phase_state_next = PH_IDLE; last_status_next = ST_OK; done_next = 1'b1;
            end else begin
              last_status_next = (cmd == OP_WADDR) ? ST_ANACK : ST_DNACK;
              auto_stop_next = 1'b1; sda_drv_next = 1'b1;
              phase_state_next = PH_STOP1; phase_counter_next = ticks;
            end
          end
          PH_RHIGH: begin
            if (sda) shift_byte_next = shift_byte | (8'h80 >> bit_index[2:0]);
            scl_drv_next = 1'b1;
            bit_index_next = bi_inc;
            phase_counter_next = ticks;
            if (bi_inc < 4'd8) begin
              sda_drv_next = 1'b0; phase_state_next = PH_RLOW;
            end else begin
              sda_drv_next = (cmd == OP_RACK); phase_state_next = PH_RACKLOW;
            end
          end
          PH_RACKLOW: begin
            scl_drv_next = 1'b0; phase_state_next = PH_RACKHIGH; phase_counter_next = ticks;
          end
          PH_RACKHIGH: begin
            scl_drv_next = 1'b1; sda_drv_next = 1'b0; rx_reg_next = shift_byte;
            phase_state_next = PH_IDLE; last_status_next = ST_OK; done_next = 1'b1;
          end
          PH_STOP1: begin
            scl_drv_next = 1'b0; phase_state_next = PH_STOP2; phase_counter_next = ticks;
          end
          PH_STOP2: begin
            sda_drv_next = 1'b0; phase_state_next = PH_STOP3; phase_counter_next = ticks;
          end
          PH_STOP3: begin
            phase_state_next = PH_IDLE; done_next = 1'b1;
            last_status_next = auto_stop ? last_status : ST_OK;
            auto_stop_next = 1'b0;
          end
          default: begin
            phase_state_next = PH_IDLE; phase_counter_next = 16'd0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      obuf.scl_drive_low <= scl_drv_next;
      obuf.sda_drive_low <= sda_drv_next;
      obuf.ready_res     <= (phase_state_next == PH_IDLE);
      obuf.done_res      <= done_next;
      obuf.rx_byte       <= rx_reg_next;
      obuf.status        <= last_status_next;
    end
    if (rst) begin
      ov <= 1'b0;
      phase_state <= PH_IDLE; phase_counter <= 16'd0; bit_index <= 4'd0;
      shift_byte <= 8'd0; stretch_counter <= 16'd0; recovery_counter <= 8'd0;
      last_status <= ST_OK; auto_stop <= 1'b0; scl_drv <= 1'b0; sda_drv <= 1'b0;
      rx_reg <= 8'd0; cmd <= OP_NONE;
    end else begin
      if (step) ov <= 1'b1;
      else if (!out_stall) ov <= 1'b0;
      if (step) begin
        phase_state <= phase_state_next; phase_counter <= phase_counter_next;
        bit_index <= bit_index_next; shift_byte <= shift_byte_next;
        stretch_counter <= stretch_counter_next;
        recovery_counter <= recovery_counter_next;
        last_status <= last_status_next; auto_stop <= auto_stop_next;
        scl_drv <= scl_drv_next; sda_drv <= sda_drv_next;
        rx_reg <= rx_reg_next; cmd <= cmd_next;
      end
    end
  end
endmodule

// ----- src/i2c_master_byte_engine.sv -----
// top level of the i2c master byte engine: config registers, front, queue, back
//
//  channel | direction | beat                 | handshake
//  in      | input     | in_item_t (tick)     | in_valid / in_stall
//  out     | output    | out_item_t (result)  | out_valid / out_stall
//  apb     | input     | 32 bit register data | psel / penable / pready
//
// one input beat per cycle unless out stalls, one result beat per input beat; each beat
// passes the front register, the queue and the result register.
// the bit sequencer updates its whole state on each step, which sets the rate.
// rst is synchronous and active high; control and config registers return to their reset values.
// a stall on out holds the sequencer; the queue and front register absorb beats.
module i2c_master_byte_engine (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cm_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output i2cm_pkg::out_item_t out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import i2cm_pkg::*;

  cfg_t     cfg;
  logic     fq_valid, fq_stall, qb_valid, qb_take;
  in_item_t fq_data, qb_data;
  logic [1:0] ridx;

  assign pready = 1'b1;
  assign ridx   = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.phase_ticks     <= 16'd60;
      cfg.stretch_enable  <= 1'b0;
      cfg.stretch_limit   <= 16'd1000;
      cfg.recovery_pulses <= 8'd100;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        REG_PHASE:   cfg.phase_ticks     <= pwdata[15:0];
        REG_STR_EN:  cfg.stretch_enable  <= pwdata[0];
        REG_STR_LIM: cfg.stretch_limit   <= pwdata[15:0];
        REG_REC:     cfg.recovery_pulses <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_PHASE:   prdata = {16'd0, cfg.phase_ticks};
      REG_STR_EN:  prdata = {31'd0, cfg.stretch_enable};
      REG_STR_LIM: prdata = {16'd0, cfg.stretch_limit};
      REG_REC:     prdata = {24'd0, cfg.recovery_pulses};
      default:     prdata = 32'd0;
    endcase
  end

  i2cm_front u_front (
    .clk, .rst, .in_valid, .in_stall, .in_data,
    .q_valid(fq_valid), .q_stall(fq_stall), .q_data(fq_data)
  );

  i2cm_queue u_queue (
    .clk, .rst, .wr_valid(fq_valid), .wr_stall(fq_stall), .wr_data(fq_data),
    .rd_valid(qb_valid), .rd_take(qb_take), .rd_data(qb_data)
  );

  i2cm_back u_back (
    .clk, .rst, .cfg, .q_valid(qb_valid), .q_take(qb_take), .q_data(qb_data),
    .out_valid, .out_stall, .out_data
  );
endmodule

// ----- src/i2cm_checker.sv -----
// port-level checker for the i2c master byte engine, bound to the top level
module i2cm_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input i2cm_pkg::out_item_t out_data
);
  import i2cm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  a_done_ready: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.done_res |-> out_data.ready_res)
    else $error("done without idle");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.status <= ST_RECFAIL)
    else $error("status code out of range");

  a_no_out_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result after reset");

  a_in_free_after_reset: assert property (@(posedge clk)
    rst |=> !in_stall)
    else $error("input stalled after reset");
endmodule

bind i2c_master_byte_engine i2cm_checker u_checker (
  .clk, .rst, .in_stall, .out_valid, .out_stall, .out_data
);
